### sv/cls_pkg.sv
// Shared constants, types and codes for the combined LCG shuffle generator.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package cls_pkg;

  // Sizes
  localparam int TABLE_SIZE  = 32;
  localparam int SLOT_BITS   = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int WARM_STEPS  = TABLE_SIZE + 8;
  localparam int WARM_W      = $clog2(WARM_STEPS);
  localparam int VAL_W       = 31;
  localparam int MUL_W       = 16;
  localparam int PROD_W      = VAL_W + MUL_W;
  localparam int FOLD_W      = 8;
  localparam int FOLD_PROD_W = MUL_W + FOLD_W;

  // Generator constants; both moduli sit just below 2^31
  localparam logic [VAL_W-1:0]  MOD_A        = 31'd2147483563;
  localparam logic [VAL_W-1:0]  MOD_B        = 31'd2147483399;
  localparam logic [MUL_W-1:0]  MUL_A        = 16'd40014;
  localparam logic [MUL_W-1:0]  MUL_B        = 16'd40692;
  localparam logic [FOLD_W-1:0] FOLD_A       = FOLD_W'(32'h8000_0000 - 32'(MOD_A));
  localparam logic [FOLD_W-1:0] FOLD_B       = FOLD_W'(32'h8000_0000 - 32'(MOD_B));
  localparam logic [VAL_W-1:0]  RANGE_TOP    = MOD_A - 31'd1;
  localparam logic [VAL_W-1:0]  SECOND_RESET = 31'd123456789;

  // Slot divisor; its multiples bound the table slots
  localparam logic [31:0] SLOT_DIV = 32'd1 + 32'(RANGE_TOP) / TABLE_SIZE;

  // Command codes
  localparam logic OP_DRAW   = 1'b0;
  localparam logic OP_RESEED = 1'b1;

  // Request into the shared modular multiplier
  typedef struct packed {
    logic             valid;
    logic             sel_b;
    logic [VAL_W-1:0] operand;
  } mm_req_t;

  // Result out of the shared modular multiplier
  typedef struct packed {
    logic             valid;
    logic             sel_b;
    logic [VAL_W-1:0] value;
  } mm_resp_t;

endpackage

### sv/cls_modmul.sv
// Shared modular multiplier: x * a mod m for either generator, two stages.
// Depends on cls_pkg for constants and the request/result structs.
`timescale 1ns / 1ps

module cls_modmul (
  input  logic              clk,
  input  logic              rst,
  input  cls_pkg::mm_req_t  req,
  output cls_pkg::mm_resp_t resp,
  output logic              busy
);
  import cls_pkg::*;

  logic                   s1_vld;
  logic                   s1_sel;
  logic [PROD_W-1:0]      prod;
  logic                   s2_vld;
  logic                   s2_sel;
  logic [VAL_W-1:0]       s2_val;

  logic [MUL_W-1:0]       mult;
  logic [FOLD_W-1:0]      fold_c;
  logic [VAL_W-1:0]       modulus;
  logic [FOLD_PROD_W-1:0] fold_prod;
  logic [31:0]            fold;
  logic [31:0]            red;

  // Pick the multiplier constant for the requesting generator
  assign mult = req.sel_b ? MUL_B : MUL_A;

  // Fold the high part back in: 2^31 == c (mod m), then one subtract
  assign fold_c    = s1_sel ? FOLD_B : FOLD_A;
  assign modulus   = s1_sel ? MOD_B : MOD_A;
  assign fold_prod = FOLD_PROD_W'(prod[PROD_W-1:VAL_W]) * FOLD_PROD_W'(fold_c);
  assign fold      = 32'(fold_prod) + {1'b0, prod[VAL_W-1:0]};
  assign red       = (fold >= {1'b0, modulus}) ? fold - {1'b0, modulus} : fold;

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else begin
      s1_vld <= req.valid;
      s2_vld <= s1_vld;
    end
  end

  // Stage data
  always_ff @(posedge clk) begin
    s1_sel <= req.sel_b;
    prod   <= PROD_W'(req.operand) * PROD_W'(mult);
    s2_sel <= s1_sel;
    s2_val <= red[VAL_W-1:0];
  end

  assign resp.valid = s2_vld;
  assign resp.sel_b = s2_sel;
  assign resp.value = s2_val;
  assign busy       = s1_vld | s2_vld;

endmodule

### sv/cls_slot_div.sv
// Slot index of the previous output: compare against each multiple of the
// slot divisor. Depends on cls_pkg; the index is registered on start.
`timescale 1ns / 1ps

module cls_slot_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [cls_pkg::VAL_W-1:0]     dividend,
  output logic [cls_pkg::SLOT_BITS-1:0] quotient
);
  import cls_pkg::*;

  logic [31:0]          thresh;
  logic [SLOT_BITS-1:0] quotient_next;

  // Count the divisor multiples at or below the dividend; top slot caps it
  always_comb begin
    thresh        = SLOT_DIV;
    quotient_next = '0;
    for (int k = 1; k < TABLE_SIZE; k++) begin
      if ({1'b0, dividend} >= thresh) begin
        quotient_next = SLOT_BITS'(k);
      end
      thresh = thresh + SLOT_DIV;
    end
  end

  // Hold the index until the next start
  always_ff @(posedge clk) begin
    if (rst) begin
      quotient <= '0;
    end else if (start) begin
      quotient <= quotient_next;
    end
  end

endmodule

### sv/cls_table.sv
// Shuffle table memory with per-entry valid bits; unwritten entries read as zero.
// Depends on cls_pkg for depth and widths. Read data is registered.
`timescale 1ns / 1ps

module cls_table (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [cls_pkg::SLOT_BITS-1:0] wr_addr,
  input  logic [cls_pkg::VAL_W-1:0]     wr_data,
  input  logic                          rd_en,
  input  logic [cls_pkg::SLOT_BITS-1:0] rd_addr,
  output logic [cls_pkg::VAL_W-1:0]     rd_data
);
  import cls_pkg::*;

  logic [VAL_W-1:0]      mem [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] vld;
  logic [VAL_W-1:0]      rd_q;
  logic                  rd_vld;

  // Valid bits: cleared by reset, set on write
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q   <= mem[rd_addr];
      rd_vld <= vld[rd_addr];
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule

### sv/combined_lcg_shuffle_rng_unit.sv
// Combined two-generator LCG with a shuffle table, one value per command.
// A draw passes the two-stage modular multiplier for both generators and then
// the registered table read; a reseed first runs 40 warm-up steps through the
// multiplier, then draws. One command at a time; the next is taken in the cycle
// after the result is registered. Synchronous reset restores seeds.
`timescale 1ns / 1ps

module combined_lcg_shuffle_rng_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_valid,
  output logic                      cmd_ready,
  input  logic                      operation,
  input  logic [cls_pkg::VAL_W-1:0] seed_value,
  output logic                      res_valid,
  input  logic                      res_ready,
  output logic [cls_pkg::VAL_W-1:0] random_value
);
  import cls_pkg::*;

  typedef enum logic [3:0] {
    IDLE,
    WARM,
    WARM_WAIT,
    DRAW_A,
    DRAW_B,
    DRAW_WAIT,
    READ,
    OUT,
    DONE
  } state_t;

  state_t             state;
  logic [VAL_W-1:0]   gen_a;
  logic [VAL_W-1:0]   gen_b;
  logic [VAL_W-1:0]   prev_out;
  logic [WARM_W-1:0]  warm_cnt;

  mm_req_t            mm_req;
  mm_resp_t           mm_resp;
  logic               mm_busy;
  logic [SLOT_BITS-1:0] slot;

  logic               tbl_wr_en;
  logic [SLOT_BITS-1:0] tbl_wr_addr;
  logic [VAL_W-1:0]   tbl_wr_data;
  logic [VAL_W-1:0]   tbl_rd_data;
  logic [VAL_W-1:0]   seed_fix;
  logic [31:0]        diff;
  logic [31:0]        draw_wide;
  logic               warm_fill;

  assign cmd_ready = (state == IDLE);

  // Zero seed becomes one
  assign seed_fix = (seed_value == '0) ? VAL_W'(1) : seed_value;

  // Multiplier requests: first generator on warm-up and draw, then the second
  assign mm_req.valid   = (state == WARM) || (state == DRAW_A) || (state == DRAW_B);
  assign mm_req.sel_b   = (state == DRAW_B);
  assign mm_req.operand = (state == DRAW_B) ? gen_b : gen_a;

  // Output value: table entry minus second generator, wrapped into range
  assign diff      = {1'b0, tbl_rd_data} - {1'b0, gen_b};
  assign draw_wide = (diff[31] || diff == '0) ? diff + 32'(RANGE_TOP) : diff;

  // Table writes: last warm-up steps fill from the top slot down; a draw refills
  assign warm_fill   = (state == WARM_WAIT) && mm_resp.valid
                       && (warm_cnt < WARM_W'(TABLE_SIZE));
  assign tbl_wr_en   = warm_fill || (state == OUT);
  assign tbl_wr_addr = (state == OUT) ? slot : warm_cnt[SLOT_BITS-1:0];
  assign tbl_wr_data = (state == OUT) ? gen_a : mm_resp.value;

  cls_modmul u_modmul (
    .clk  (clk),
    .rst  (rst),
    .req  (mm_req),
    .resp (mm_resp),
    .busy (mm_busy)
  );

  cls_slot_div u_slot_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == DRAW_A),
    .dividend (prev_out),
    .quotient (slot)
  );

  cls_table u_table (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .rd_en   (state == READ),
    .rd_addr (slot),
    .rd_data (tbl_rd_data)
  );

  // Sequencer, generator state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      gen_a     <= VAL_W'(1);
      gen_b     <= SECOND_RESET;
      prev_out  <= '0;
      warm_cnt  <= '0;
      res_valid <= 1'b0;
    end else begin
      // Drop the result once the transaction completes, unless a new one loads
      if (res_valid && res_ready && (state != DONE)) begin
        res_valid <= 1'b0;
      end

      // Capture multiplier results into their generator
      if (mm_resp.valid) begin
        if (mm_resp.sel_b) begin
          gen_b <= mm_resp.value;
        end else begin
          gen_a <= mm_resp.value;
        end
      end

      case (state)
        IDLE: begin
          if (cmd_valid) begin
            if (operation == OP_RESEED) begin
              gen_a    <= seed_fix;
              gen_b    <= seed_fix;
              warm_cnt <= WARM_W'(WARM_STEPS - 1);
              state    <= WARM;
            end else begin
              state <= DRAW_A;
            end
          end
        end
        WARM: begin
          state <= WARM_WAIT;
        end
        WARM_WAIT: begin
          if (mm_resp.valid) begin
            if (warm_cnt == '0) begin
              prev_out <= mm_resp.value;
              state    <= DRAW_A;
            end else begin
              warm_cnt <= warm_cnt - 1'b1;
              state    <= WARM;
            end
          end
        end
        DRAW_A: begin
          state <= DRAW_B;
        end
        DRAW_B: begin
          state <= DRAW_WAIT;
        end
        DRAW_WAIT: begin
          if (!mm_busy) begin
            state <= READ;
          end
        end
        READ: begin
          state <= OUT;
        end
        OUT: begin
          prev_out <= draw_wide[VAL_W-1:0];
          state    <= DONE;
        end
        DONE: begin
          // Hold until the result register is free
          if (!res_valid || res_ready) begin
            random_value <= prev_out;
            res_valid    <= 1'b1;
            state        <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // Results always land in the documented range
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (random_value != '0) && (random_value <= RANGE_TOP))
    else $error("random_value out of range");

  // Generators are reduced whenever a new command can be taken
  a_gen_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == IDLE) |-> (gen_a < MOD_A) && (gen_b < MOD_B))
    else $error("generator not reduced at idle");

  // No multiplier result arrives while the sequencer is idle
  a_no_stray_result: assert property (@(posedge clk) disable iff (rst)
    (state == IDLE) |-> !mm_resp.valid && !mm_busy)
    else $error("stray multiplier result");

  // Table read only after both generator steps have returned
  a_slot_ready: assert property (@(posedge clk) disable iff (rst)
    (state == READ) |-> !mm_busy && $past(state == DRAW_WAIT))
    else $error("table read before generators settled");

endmodule

### sim/tb_top.sv
// Self-checking bench for combined_lcg_shuffle_rng_unit: queued draw/reseed
// commands, a bit-exact generator predictor and a result checker.
// Depends on cls_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_top;
  import cls_pkg::*;

  // Schrage split of both multipliers
  localparam longint GEN_A_MOD = 64'd2147483563;
  localparam longint GEN_B_MOD = 64'd2147483399;
  localparam longint GEN_A_MUL = 64'd40014;
  localparam longint GEN_B_MUL = 64'd40692;
  localparam longint GEN_A_QUO = 64'd53668;
  localparam longint GEN_B_QUO = 64'd52774;
  localparam longint GEN_A_REM = 64'd12211;
  localparam longint GEN_B_REM = 64'd3791;
  localparam longint OUT_TOP   = GEN_A_MOD - 64'd1;
  localparam longint SLOT_STEP = 64'd1 + OUT_TOP / TABLE_SIZE;
  localparam int     WARM_RUN  = TABLE_SIZE + 8;

  localparam int RANDOM_ITEMS = 1700;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 20;
  localparam int CALM_START   = 10000;
  localparam int CALM_END     = 20000;

  typedef struct {
    logic             op;
    logic [VAL_W-1:0] seed;
  } rng_cmd_t;

  logic             clk          = 1'b0;
  logic             rst          = 1'b1;
  logic             cmd_valid    = 1'b0;
  logic             cmd_ready;
  logic             operation    = OP_DRAW;
  logic [VAL_W-1:0] seed_value   = '0;
  logic             res_valid;
  logic             res_ready    = 1'b0;
  logic [VAL_W-1:0] random_value;

  rng_cmd_t         pending_cmds[$];
  logic [VAL_W-1:0] expected_values[$];
  int               total_cmds     = 0;
  int               accepted_cmds  = 0;
  int               error_count    = 0;
  int               cycle_count    = 0;

  // Predicted generator state, as after reset
  longint gen_a_state = 64'd1;
  longint gen_b_state = 64'd123456789;
  longint last_output = 64'd0;
  longint shuffle_slots[TABLE_SIZE];

  initial begin
    foreach (shuffle_slots[i]) shuffle_slots[i] = 64'd0;
  end

  combined_lcg_shuffle_rng_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .operation    (operation),
    .seed_value   (seed_value),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .random_value (random_value)
  );

  always #5 clk = ~clk;

  // Advance a generator one Schrage step
  function automatic longint schrage_step(longint x, longint mul, longint quo,
                                          longint rem, longint modulus);
    longint k;
    longint r;
    k = x / quo;
    r = mul * (x - k * quo) - k * rem;
    if (r < 0) r = r + modulus;
    return r;
  endfunction

  // Update the predicted state for one command and return the value it yields
  function automatic logic [VAL_W-1:0] next_random(logic op, logic [VAL_W-1:0] seed);
    longint start;
    longint slot;
    start = longint'(seed);
    if (op == OP_RESEED) begin
      if (start < 1) start = 1;
      gen_a_state = start;
      gen_b_state = start;
      for (int j = WARM_RUN - 1; j >= 0; j--) begin
        gen_a_state = schrage_step(gen_a_state, GEN_A_MUL, GEN_A_QUO, GEN_A_REM, GEN_A_MOD);
        if (j < TABLE_SIZE) shuffle_slots[j] = gen_a_state;
      end
      last_output = shuffle_slots[0];
    end
    gen_a_state = schrage_step(gen_a_state, GEN_A_MUL, GEN_A_QUO, GEN_A_REM, GEN_A_MOD);
    gen_b_state = schrage_step(gen_b_state, GEN_B_MUL, GEN_B_QUO, GEN_B_REM, GEN_B_MOD);
    slot = last_output / SLOT_STEP;
    if (slot < 0) slot = 0;
    if (slot >= TABLE_SIZE) slot = TABLE_SIZE - 1;
    last_output = shuffle_slots[slot] - gen_b_state;
    shuffle_slots[slot] = gen_a_state;
    if (last_output < 1) last_output = last_output + OUT_TOP;
    return VAL_W'(last_output);
  endfunction

  // Random stall, except inside the calm window
  function automatic bit take_break();
    if (cycle_count >= CALM_START && cycle_count < CALM_END) return 1'b0;
    return $urandom_range(0, 99) < 10;
  endfunction

  task automatic queue_cmd(logic op, logic [VAL_W-1:0] seed);
    rng_cmd_t c;
    c.op   = op;
    c.seed = seed;
    pending_cmds.push_back(c);
    total_cmds++;
  endtask

  // Mostly full-range seeds, sometimes an edge value: small, all-ones or near a modulus
  function automatic logic [VAL_W-1:0] pick_seed();
    logic [VAL_W-1:0] edges[10];
    edges = '{31'd0, 31'd1, 31'd2, 31'h7FFF_FFFF, 31'd2147483563, 31'd2147483562,
              31'd2147483564, 31'd2147483399, 31'd2147483398, 31'd2147483400};
    if ($urandom_range(0, 99) < 12) return edges[$urandom_range(0, 9)];
    return VAL_W'($urandom());
  endfunction

  // Fill the command queue, then wait for the drain
  initial begin
    int burst;
    // Draws from the reset state, before any reseed
    queue_cmd(OP_DRAW, 31'd0);
    queue_cmd(OP_DRAW, 31'h7FFF_FFFF);
    queue_cmd(OP_DRAW, 31'h2AAA_AAAA);
    // Zero seed acts as one
    queue_cmd(OP_RESEED, 31'd0);
    queue_cmd(OP_DRAW, 31'h5555_5555);
    queue_cmd(OP_RESEED, 31'd1);
    queue_cmd(OP_DRAW, 31'd0);
    // Largest seed, above both moduli
    queue_cmd(OP_RESEED, 31'h7FFF_FFFF);
    queue_cmd(OP_DRAW, 31'd0);
    queue_cmd(OP_DRAW, 31'd0);
    // Seed equal to the first modulus pins the first generator at zero
    queue_cmd(OP_RESEED, 31'd2147483563);
    queue_cmd(OP_DRAW, 31'd0);
    queue_cmd(OP_DRAW, 31'd0);
    queue_cmd(OP_DRAW, 31'd0);
    // Seed equal to the second modulus pins the second generator at zero
    queue_cmd(OP_RESEED, 31'd2147483399);
    queue_cmd(OP_DRAW, 31'd0);
    queue_cmd(OP_DRAW, 31'd0);
    queue_cmd(OP_DRAW, 31'd0);
    // Seeds just around the moduli
    queue_cmd(OP_RESEED, 31'd2147483562);
    queue_cmd(OP_DRAW, 31'd0);
    queue_cmd(OP_RESEED, 31'd2147483400);
    queue_cmd(OP_DRAW, 31'h7FFF_FFFF);
    queue_cmd(OP_RESEED, 31'h4000_0000);

    // Reseed-then-draw runs with random content, plus some noise
    while (total_cmds < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 85) begin
        queue_cmd(OP_RESEED, pick_seed());
        burst = $urandom_range(4, 30);
        repeat (burst) queue_cmd(OP_DRAW, VAL_W'($urandom()));
      end else begin
        burst = $urandom_range(1, 6);
        repeat (burst) begin
          if ($urandom_range(0, 3) == 0) queue_cmd(OP_RESEED, pick_seed());
          else queue_cmd(OP_DRAW, VAL_W'($urandom()));
        end
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (accepted_cmds < total_cmds) @(posedge clk);
    while (expected_values.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Driver: record the accepted transaction, then present the next one
  always @(posedge clk) begin
    rng_cmd_t c;
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && cmd_ready) begin
        expected_values.push_back(next_random(operation, seed_value));
        accepted_cmds++;
      end
      if (!cmd_valid || cmd_ready) begin
        if (pending_cmds.size() > 0 && !take_break()) begin
          c = pending_cmds.pop_front();
          cmd_valid  <= 1'b1;
          operation  <= c.op;
          seed_value <= c.seed;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transaction against the oldest prediction
  always @(posedge clk) begin
    logic [VAL_W-1:0] want;
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        if (expected_values.size() == 0) begin
          $display("%0t: unexpected result random_value=%0d", $time, random_value);
          error_count++;
        end else begin
          want = expected_values.pop_front();
          if (random_value !== want) begin
            $display("%0t: random_value mismatch expected=%0d actual=%0d",
                     $time, want, random_value);
            error_count++;
          end
        end
      end
      res_ready <= !take_break();
    end
  end

  // Drop the run if it hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule

### sim.f
sv/cls_pkg.sv
sv/cls_modmul.sv
sv/cls_slot_div.sv
sv/cls_table.sv
sv/combined_lcg_shuffle_rng_unit.sv
sim/tb_top.sv
